// ----- hdl/cmrs_pkg.sv -----
// Shared constants and request codes for the counted multiset range sum core.
package cmrs_pkg;

    localparam int OPERAND_W = 31;
    localparam int ANSWER_W  = 48;
    localparam int MODULUS_W = 11;
    localparam int SUM_W     = ANSWER_W + 1;

    localparam logic [MODULUS_W-1:0] MODULUS_RESET = 11'd1024;
    localparam logic [ANSWER_W-1:0]  ANS_MAX       = '1;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_RANGE  = 2'd2;

endpackage

// ----- hdl/counted_multiset_range_sum_core.sv -----
// Top level of the counted multiset range sum core.
// Each request beat has its operands decoded in a bit-serial remainder unit, which
// handles both operands at once. Insert and remove then do one read-modify-write of
// the count table, reading it as decoding ends and writing it in the update state; a
// remove also loads its result beat in the result state. A range request reads one
// table entry per cycle over the keys from low + 1 up to high. A remove or range result
// also waits while an earlier result beat is still not taken. A request type of 3 is
// taken and dropped. After reset the count table is cleared one entry per cycle, so no
// request is taken until all KEY_SPACE entries are cleared; modulus writes are taken
// at any time. A new request is taken while an earlier result beat still waits on the
// output.
module counted_multiset_range_sum_core import cmrs_pkg::*; #(
    parameter int KEY_SPACE  = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [MODULUS_W-1:0]  cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [OPERAND_W-1:0]  s_first_operand,
    input  logic [OPERAND_W-1:0]  s_second_operand,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ANSWER_W-1:0]   m_answer
);

    localparam int KEY_W  = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
    localparam int PROD_W = KEY_W + COUNT_BITS;
    localparam int CMP_W  = (PROD_W > ANSWER_W) ? PROD_W : ANSWER_W;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_UPDATE, ST_SWEEP, ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic [MODULUS_W-1:0]   modulus_reg;
    logic [ANSWER_W-1:0]    last_answer_reg;
    logic [KEY_W-1:0]       clr_cnt_reg;
    logic [1:0]             req_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W:0]         k_reg;
    logic [KEY_W-1:0]       hi_reg;
    logic                   p1_vld_reg, p2_vld_reg;
    logic [KEY_W-1:0]       p1_key_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ANSWER_W-1:0]    acc_reg, acc_next;
    logic [ANSWER_W-1:0]    res_reg;
    logic                   m_valid_reg;
    logic [ANSWER_W-1:0]    m_answer_reg;

    logic                   dec_start, dec_done;
    logic [KEY_W-1:0]       dec_key_a, dec_key_b, dec_lo, dec_hi;
    logic                   sweep_issue;
    logic [ANSWER_W-1:0]    headroom;

    logic                   ram_wr_en, ram_rd_en;
    logic [KEY_W-1:0]       ram_wr_addr, ram_rd_addr;
    logic [COUNT_BITS-1:0]  ram_wr_data, ram_rd_data;

    assign s_ready   = (state_reg == ST_IDLE);
    assign dec_start = s_valid && s_ready &&
                       (s_req_type == REQ_INSERT || s_req_type == REQ_REMOVE ||
                        s_req_type == REQ_RANGE);

    cmrs_decode #(.KEY_SPACE(KEY_SPACE)) u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (dec_start),
        .first_operand  (s_first_operand),
        .second_operand (s_second_operand),
        .last_answer    (last_answer_reg),
        .modulus        (modulus_reg),
        .done           (dec_done),
        .key_a          (dec_key_a),
        .key_b          (dec_key_b)
    );

    cmrs_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << KEY_W)) u_count_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign dec_lo      = (dec_key_a < dec_key_b) ? dec_key_a : dec_key_b;
    assign dec_hi      = (dec_key_a < dec_key_b) ? dec_key_b : dec_key_a;
    assign sweep_issue = (state_reg == ST_SWEEP) && (k_reg <= {1'b0, hi_reg});
    assign ram_rd_en   = ((state_reg == ST_DECODE) && dec_done) || sweep_issue;
    assign ram_rd_addr = (state_reg == ST_SWEEP) ? k_reg[KEY_W-1:0] : dec_key_a;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = key_reg;
        ram_wr_data = ram_rd_data + 1'b1;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = '0;
            end
            ST_UPDATE: begin
                if (req_reg == REQ_INSERT) begin
                    ram_wr_en = (ram_rd_data != '1);
                end else begin
                    ram_wr_en   = (ram_rd_data != '0);
                    ram_wr_data = ram_rd_data - 1'b1;
                end
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    assign headroom = ANS_MAX - acc_reg;
    assign acc_next = (CMP_W'(prod_reg) > CMP_W'(headroom))
                      ? ANS_MAX : acc_reg + ANSWER_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            modulus_reg     <= MODULUS_RESET;
            last_answer_reg <= '0;
            p1_vld_reg      <= 1'b0;
            p2_vld_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                modulus_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            p1_vld_reg <= sweep_issue;
            p1_key_reg <= k_reg[KEY_W-1:0];
            p2_vld_reg <= p1_vld_reg;
            prod_reg   <= PROD_W'(p1_key_reg) * PROD_W'(ram_rd_data);
            if (p2_vld_reg) begin
                acc_reg <= acc_next;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == KEY_W'(KEY_SPACE - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (dec_start) begin
                        req_reg   <= s_req_type;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    if (dec_done) begin
                        if (req_reg == REQ_RANGE) begin
                            k_reg     <= {1'b0, dec_lo} + 1'b1;
                            hi_reg    <= dec_hi;
                            acc_reg   <= '0;
                            state_reg <= ST_SWEEP;
                        end else begin
                            key_reg   <= dec_key_a;
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE: begin
                    res_reg <= ANSWER_W'(ram_rd_data);
                    if (req_reg == REQ_REMOVE) begin
                        state_reg <= ST_RESULT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SWEEP: begin
                    if (sweep_issue) begin
                        k_reg <= k_reg + 1'b1;
                    end else if (!p1_vld_reg && !p2_vld_reg) begin
                        res_reg   <= acc_reg;
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_answer_reg <= res_reg;
                        if (req_reg == REQ_RANGE) begin
                            last_answer_reg <= res_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_answer = m_answer_reg;

    a_result_from_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RESULT))
        else $error("result beat raised outside the result state");

    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> !ram_wr_en)
        else $error("count table written during a range sweep");

    a_decode_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_done |-> (state_reg == ST_DECODE))
        else $error("decoder finished while no request was waiting on it");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (k_reg <= ({1'b0, hi_reg} + 1'b1)))
        else $error("sweep key ran past the upper bound");

endmodule

// ----- hdl/cmrs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module cmrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/cmrs_decode.sv -----
// Bit-serial operand decoder: two remainders of (operand + last answer) by the modulus (KEY_SPACE if 0 or > KEY_SPACE).
module cmrs_decode import cmrs_pkg::*; #(
    parameter int KEY_SPACE = 1024
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic [OPERAND_W-1:0]                      first_operand,
    input  logic [OPERAND_W-1:0]                      second_operand,
    input  logic [ANSWER_W-1:0]                       last_answer,
    input  logic [MODULUS_W-1:0]                      modulus,
    output logic                                      done,
    output logic [((KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1)-1:0] key_a,
    output logic [((KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1)-1:0] key_b
);

    localparam int KEY_W   = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
    localparam int M_W     = $clog2(KEY_SPACE + 1);
    localparam int CMP_W   = (M_W > MODULUS_W) ? M_W : MODULUS_W;
    localparam int STEP_W  = $clog2(SUM_W);

    logic [SUM_W-1:0]  sum_a_reg, sum_b_reg;
    logic [M_W-1:0]    rem_a_reg, rem_b_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [M_W-1:0]    eff_mod;

    function automatic logic [M_W-1:0] rem_step(input logic [M_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [M_W-1:0] m);
        logic [M_W:0] shifted;
        shifted = {rem, bit_in};
        if (shifted >= {1'b0, m}) begin
            rem_step = M_W'(shifted - {1'b0, m});
        end else begin
            rem_step = M_W'(shifted);
        end
    endfunction

    assign eff_mod = (modulus == '0 || CMP_W'(modulus) > CMP_W'(KEY_SPACE))
                     ? M_W'(KEY_SPACE) : M_W'(modulus);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                sum_a_reg <= SUM_W'(first_operand) + SUM_W'(last_answer);
                sum_b_reg <= SUM_W'(second_operand) + SUM_W'(last_answer);
                rem_a_reg <= '0;
                rem_b_reg <= '0;
                cnt_reg   <= STEP_W'(SUM_W - 1);
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                rem_a_reg <= rem_step(rem_a_reg, sum_a_reg[SUM_W-1], eff_mod);
                rem_b_reg <= rem_step(rem_b_reg, sum_b_reg[SUM_W-1], eff_mod);
                sum_a_reg <= {sum_a_reg[SUM_W-2:0], 1'b0};
                sum_b_reg <= {sum_b_reg[SUM_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign key_a = rem_a_reg[KEY_W-1:0];
    assign key_b = rem_b_reg[KEY_W-1:0];

endmodule
